// File: design/assert_macros.svh
// Assertion helpers used by the top-level supervisor.
// The checking forms are compiled for simulation; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on aclk and ignored while in reset.
`define SSMS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and ignored while in reset.
`define SSMS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SSMS_ASSERT_IMP(lbl, ante, cons, msg)
`define SSMS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: design/ssms_pkg.sv
package ssms_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DRAG_CURRENT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPEN_TO_CLOSED_SPEED = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOSED_TO_OPEN_SPEED = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_CLOSED_SPEED     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECOVERY_TICKS       = 3'd4;
    localparam int CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [15:0] MAX_DRAG_RESET      = 16'd20000;
    localparam logic [14:0] OPEN_TO_CLOSED_RESET = 15'd300;
    localparam logic [14:0] CLOSED_TO_OPEN_RESET = 15'd200;
    localparam logic [14:0] MIN_CLOSED_RESET    = 15'd150;
    localparam logic [15:0] RECOVERY_RESET      = 16'd5000;

    // Ramp generator states.
    localparam logic [1:0] RAMP_OPEN   = 2'd0;
    localparam logic [1:0] RAMP_CLOSED = 2'd1;
    localparam logic [1:0] RAMP_DECEL  = 2'd2;

    // Supervisor constants.
    localparam logic [15:0] RUN_TICKS_MAX   = 16'd40000;
    localparam logic [15:0] STALL_RUN_TICKS = 16'd20000;
    localparam logic [5:0]  CONVERGE_MAX    = 6'd41;
    localparam logic signed [6:0] CONVERGE_LIMIT = 7'sd30;
    localparam logic signed [15:0] ANGLE_TOL = 16'sd3276;
    localparam logic signed [17:0] FLOOR_DOWN   = 18'sd800;
    localparam logic signed [17:0] FLOOR_UP     = 18'sd500;
    localparam logic signed [17:0] STEP_UP_FAST = 18'sd100;
    localparam logic signed [17:0] STEP_UP_SLOW = 18'sd10;
    localparam logic [16:0] DECEL_MARGIN = 17'd5;

    // Down step is floor(max * 3 / 10000); the largest value it takes.
    localparam int DOWN_DIVISOR    = 10000;
    localparam int DOWN_STEP_TOP   = (65535 * 3) / DOWN_DIVISOR;
    localparam int DOWN_STEP_W     = $clog2(DOWN_STEP_TOP + 1);

    typedef struct packed {
        logic [15:0] max_drag_current;
        logic [14:0] open_to_closed_speed;
        logic [14:0] closed_to_open_speed;
        logic [14:0] min_closed_speed;
        logic [15:0] recovery_ticks;
    } cfg_t;

    // Input item, first field in the highest bits.
    typedef struct packed {
        logic [1:0]         ramp_state;
        logic signed [15:0] observer_speed;
        logic signed [15:0] ramp_speed;
        logic [15:0]        observed_angle;
        logic [15:0]        reference_angle;
    } in_item_t;

    // Result item, first field in the highest bits.
    typedef struct packed {
        logic        angle_takeover;
        logic        hold_release;
        logic        hold_start;
        logic [15:0] error_count;
        logic        error_active;
        logic [15:0] drag_current;
        logic        closed_loop;
    } res_t;

    localparam int IN_ITEM_W = $bits(in_item_t);
    localparam int RES_W     = $bits(res_t);

    // Division by the constant divisor as a row of threshold compares.
    function automatic logic [DOWN_STEP_W-1:0] down_step(input logic [15:0] max_i);
        logic [17:0] triple;
        logic [DOWN_STEP_W-1:0] q;
        triple = {1'b0, max_i, 1'b0} + {2'b00, max_i};
        q = '0;
        for (int k = 1; k <= DOWN_STEP_TOP; k++) begin
            if (triple >= 18'(k * DOWN_DIVISOR)) begin
                q = DOWN_STEP_W'(k);
            end
        end
        return q;
    endfunction

endpackage

// File: design/ssms_cfg.sv
module ssms_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ssms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ssms_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output ssms_pkg::cfg_t                   cfg
);
    import ssms_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; unknown indexes leave every register alone.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAX_DRAG_CURRENT:     cfg_next.max_drag_current     = cfg_wdata;
                CFG_OPEN_TO_CLOSED_SPEED: cfg_next.open_to_closed_speed = cfg_wdata[14:0];
                CFG_CLOSED_TO_OPEN_SPEED: cfg_next.closed_to_open_speed = cfg_wdata[14:0];
                CFG_MIN_CLOSED_SPEED:     cfg_next.min_closed_speed     = cfg_wdata[14:0];
                CFG_RECOVERY_TICKS:       cfg_next.recovery_ticks       = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_drag_current     <= MAX_DRAG_RESET;
            cfg_reg.open_to_closed_speed <= OPEN_TO_CLOSED_RESET;
            cfg_reg.closed_to_open_speed <= CLOSED_TO_OPEN_RESET;
            cfg_reg.min_closed_speed     <= MIN_CLOSED_RESET;
            cfg_reg.recovery_ticks       <= RECOVERY_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/ssms_core.sv
module ssms_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  ssms_pkg::in_item_t item,
    input  ssms_pkg::cfg_t     cfg,
    output ssms_pkg::res_t     result
);
    import ssms_pkg::*;

    logic [5:0]  converge_reg, converge_next;
    logic [15:0] run_ticks_reg, run_ticks_next;
    logic [15:0] drag_reg, drag_next;
    logic        mode_closed_reg, mode_closed_next;
    logic        error_flag_reg, error_flag_next;
    logic [15:0] error_total_reg, error_total_next;
    logic [15:0] hold_ticks_reg, hold_ticks_next;

    logic signed [15:0] angle_err;
    logic               converged;
    logic [15:0]        open_abs;
    logic [15:0]        obs_abs;
    logic [15:0]        o2c;
    logic [15:0]        c2o;
    logic [15:0]        vmin;
    logic signed [17:0] down;
    logic               decel;
    logic signed [6:0]  conv_tmp;
    logic [15:0]        run_ticks_inc;
    logic signed [17:0] drag_cand;
    logic signed [17:0] drag_floor;
    logic signed [17:0] drag_raised;
    logic               drag_update;
    logic               start;
    logic               release_hold;
    logic               takeover;

    // Raise to the floor first, then limit to the maximum; the maximum wins.
    function automatic logic [15:0] clamp_drag(input logic signed [17:0] v,
                                               input logic signed [17:0] fl,
                                               input logic [15:0] mx);
        logic signed [17:0] t;
        t = (v < fl) ? fl : v;
        if (t > $signed({2'b00, mx})) begin
            t = $signed({2'b00, mx});
        end
        return t[15:0];
    endfunction

    // Error terms and speed magnitudes.
    always_comb begin
        angle_err = $signed(item.reference_angle - item.observed_angle);
        converged = (angle_err >= -ANGLE_TOL) && (angle_err <= ANGLE_TOL);
        open_abs  = item.ramp_speed[15] ? 16'(~item.ramp_speed + 16'sd1)
                                        : 16'(item.ramp_speed);
        obs_abs   = item.observer_speed[15] ? 16'(~item.observer_speed + 16'sd1)
                                            : 16'(item.observer_speed);
        o2c   = {1'b0, cfg.open_to_closed_speed};
        c2o   = {1'b0, cfg.closed_to_open_speed};
        vmin  = {1'b0, cfg.min_closed_speed};
        down  = $signed({{(18-DOWN_STEP_W){1'b0}}, down_step(cfg.max_drag_current)});
        decel = (item.ramp_state == RAMP_DECEL);
        conv_tmp = $signed({1'b0, converge_reg}) + (converged ? 7'sd1 : -7'sd1);
        run_ticks_inc = (run_ticks_reg >= RUN_TICKS_MAX) ? RUN_TICKS_MAX
                                                         : run_ticks_reg + 16'd1;
    end

    // Drag current step: one of four rules, or no change.
    always_comb begin
        drag_update = 1'b1;
        drag_cand   = $signed({2'b00, drag_reg}) - down;
        drag_floor  = FLOOR_DOWN;
        if (!decel && open_abs >= o2c && conv_tmp <= CONVERGE_LIMIT) begin
            drag_cand  = $signed({2'b00, drag_reg}) - down;
            drag_floor = FLOOR_DOWN;
        end else if (!decel && open_abs < o2c) begin
            drag_cand  = $signed({2'b00, drag_reg}) + STEP_UP_FAST;
            drag_floor = FLOOR_UP;
        end else if (decel && vmin < open_abs
                     && ({1'b0, o2c} + DECEL_MARGIN) > {1'b0, open_abs}) begin
            drag_cand  = $signed({2'b00, drag_reg}) + STEP_UP_SLOW;
            drag_floor = FLOOR_UP;
        end else if (decel && open_abs < vmin) begin
            drag_cand  = $signed({2'b00, drag_reg}) - down;
            drag_floor = FLOOR_DOWN;
        end else begin
            drag_update = 1'b0;
        end
        drag_raised = drag_cand;
        drag_next = drag_update ? clamp_drag(drag_raised, drag_floor, cfg.max_drag_current)
                                : drag_reg;
    end

    // Mode switching, stall detection and the error hold.
    always_comb begin
        run_ticks_next   = (item.ramp_state == RAMP_CLOSED) ? run_ticks_inc : run_ticks_reg;
        mode_closed_next = mode_closed_reg;
        error_flag_next  = error_flag_reg;
        error_total_next = error_total_reg;
        hold_ticks_next  = hold_ticks_reg;
        start        = 1'b0;
        release_hold = 1'b0;
        takeover     = 1'b0;

        if (item.ramp_state == RAMP_OPEN && obs_abs < vmin
            && run_ticks_next > STALL_RUN_TICKS) begin
            error_flag_next = 1'b1;
            if (error_total_reg != 16'hFFFF) begin
                error_total_next = error_total_reg + 16'd1;
            end
            run_ticks_next = '0;
        end else if (!mode_closed_reg && open_abs > o2c) begin
            error_flag_next  = 1'b0;
            mode_closed_next = 1'b1;
        end else if (open_abs < c2o) begin
            run_ticks_next   = '0;
            mode_closed_next = 1'b0;
        end

        if (conv_tmp < 7'sd0) begin
            converge_next = '0;
        end else if (conv_tmp > $signed({1'b0, CONVERGE_MAX})) begin
            converge_next = CONVERGE_MAX;
        end else begin
            converge_next = conv_tmp[5:0];
        end

        if (error_flag_next) begin
            if (hold_ticks_reg == '0) begin
                start            = 1'b1;
                mode_closed_next = 1'b0;
            end
            if (({1'b0, hold_ticks_reg} + 17'd1) > {1'b0, cfg.recovery_ticks}) begin
                hold_ticks_next = '0;
                error_flag_next = 1'b0;
                release_hold    = 1'b1;
            end else begin
                hold_ticks_next = hold_ticks_reg + 16'd1;
            end
        end else if (item.ramp_state == RAMP_CLOSED) begin
            takeover = 1'b1;
        end

        result.closed_loop    = mode_closed_next;
        result.drag_current   = drag_next;
        result.error_active   = error_flag_next;
        result.error_count    = error_total_next;
        result.hold_start     = start;
        result.hold_release   = release_hold;
        result.angle_takeover = takeover;
    end

    // Supervisor state, updated once per processed item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            converge_reg    <= '0;
            run_ticks_reg   <= '0;
            drag_reg        <= '0;
            mode_closed_reg <= 1'b0;
            error_flag_reg  <= 1'b0;
            error_total_reg <= '0;
            hold_ticks_reg  <= '0;
        end else if (step) begin
            converge_reg    <= converge_next;
            run_ticks_reg   <= run_ticks_next;
            drag_reg        <= drag_next;
            mode_closed_reg <= mode_closed_next;
            error_flag_reg  <= error_flag_next;
            error_total_reg <= error_total_next;
            hold_ticks_reg  <= hold_ticks_next;
        end
    end

endmodule

// File: design/sensorless_startup_mode_supervisor.sv
// Channel   Direction  Bits  Contents
// s_axis    in         72    one control tick of angles, speeds and ramp state
// m_axis    out        40    mode, drag current, error status and pulses
// cfg       in         16    register writes, index 0..4
//
// One item per clock is sustained while m_tready is high; a request goes
// through the input register, then the result register. The state update
// for a tick happens as it moves into the result register, so the next
// tick sees it in the following cycle. A stalled result holds the pipeline;
// the input register still takes one request while the result waits. Reset
// is synchronous; it clears valids and core state and loads config defaults.
module sensorless_startup_mode_supervisor (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // reference_angle[15:0], observed_angle[31:16], ramp_speed[47:32],
    // observer_speed[63:48], ramp_state[65:64], zero fill[71:66]
    input  logic [71:0]                      s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // closed_loop[0], drag_current[16:1], error_active[17], error_count[33:18],
    // hold_start[34], hold_release[35], angle_takeover[36], zero fill[39:37]
    output logic [39:0]                      m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [ssms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ssms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import ssms_pkg::*;
    `include "assert_macros.svh"

    logic     in_valid_reg;
    in_item_t in_item_reg;
    logic     out_valid_reg;
    res_t     out_res_reg;
    logic     advance;
    cfg_t     cfg;
    res_t     result;

    ssms_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ssms_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Handshake: the held item moves on whenever the result slot frees up.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= in_item_t'(s_tdata[IN_ITEM_W-1:0]);
        end
        if (advance) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(40-RES_W){1'b0}}, out_res_reg};

    `SSMS_ASSERT_IMP(a_ready_only_when_full, !s_tready, in_valid_reg, "input stalled while empty")
    `SSMS_ASSERT_NXT(a_advance_gives_result, advance, m_tvalid, "processed item gave no result")
    `SSMS_ASSERT_IMP(a_release_clears_error, m_tvalid && out_res_reg.hold_release,
                     !out_res_reg.error_active, "error still set on hold release")
    `SSMS_ASSERT_IMP(a_start_forces_open, m_tvalid && out_res_reg.hold_start,
                     !out_res_reg.closed_loop, "closed loop kept at hold start")
    `SSMS_ASSERT_IMP(a_takeover_no_error, m_tvalid && out_res_reg.angle_takeover,
                     !out_res_reg.error_active, "angle takeover during error")

endmodule
